/* rtl/fnv1a_splitmix_binding_hash_core_defines.svh */
// Assertion macros shared by the hash core.
`ifndef FNV1A_SPLITMIX_BINDING_HASH_CORE_DEFINES_SVH
`define FNV1A_SPLITMIX_BINDING_HASH_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define FBH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define FBH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/fbh_pkg.sv */
package fbh_pkg;

  // FNV-1a 64-bit constants
  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

  // splitmix64 finalizer constants
  localparam logic [63:0] SM_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL_B  = 64'h94d049bb133111eb;
  localparam logic [5:0]  XS_SHIFT0 = 6'd30;
  localparam logic [5:0]  XS_SHIFT1 = 6'd27;
  localparam logic [5:0]  XS_SHIFT2 = 6'd31;

  // Finalizer rounds: two multiply rounds, then the closing xor-shift
  localparam logic [1:0]  ROUND_LAST = 2'd2;

  // Multiply phases over the shared 32x32 multiplier
  localparam logic [1:0]  PH_LOLO = 2'd0;
  localparam logic [1:0]  PH_LOHI = 2'd1;
  localparam logic [1:0]  PH_HILO = 2'd2;
  localparam logic [1:0]  PH_SUM  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_XS,
    ST_MUL,
    ST_OUT
  } fbh_state_e;

  // One FNV-1a byte step; prime 2^40 + 0x1b3 as shifts and adds
  function automatic logic [63:0] fnv_step(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
  endfunction

endpackage

/* rtl/fbh_mul32.sv */
// Shared 32x32 multiplier with registered product
module fbh_mul32 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);
  logic [63:0] prod_q;
  logic [63:0] prod_d;

  assign prod_d = en_i ? (64'(a_i) * 64'(b_i)) : prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

/* rtl/fnv1a_splitmix_binding_hash_core.sv */
// FNV-1a 64-bit message hash with build-id fold and splitmix64 finalizer.
// Input channel (in_valid_i / in_stall_o): one message byte per item with
// last_byte_i marking the final byte. A byte not marked last is taken
// without stalling the input and updates the running hash; no result follows.
// Last byte: the block stalls its input while it folds the eight bytes of
// build_id (one FNV step per cycle), then runs the splitmix64 finalizer.
// Each 64-bit multiply is three 32x32 partial products through one shared
// registered multiplier plus a sum phase. A last byte passes through 8 fold
// steps, xor-shift and multiply twice (4 phases each), a closing xor-shift
// and the output load. The running hash returns to the offset basis at once.
// Output channel (out_valid_o / out_stall_i): one registered result slot.
// Non-last bytes keep flowing while a result waits; a finished result stalls
// the core only when the slot is still held by an earlier stalled result.
// Config channel (cfg_valid_i / cfg_ready_o): always ready, writes build_id.
// Write it only while the core is idle.
// Reset (rst_ni low, async): hash = offset basis, build_id = 0, no result.
`include "fnv1a_splitmix_binding_hash_core_defines.svh"

module fnv1a_splitmix_binding_hash_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] mask_o
);
  import fbh_pkg::*;

  fbh_state_e  state_q, state_d;
  logic [63:0] hash_q, hash_d;
  logic [63:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] build_id_q, build_id_d;
  logic [63:0] mask_q, mask_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  ph_q, ph_d;
  logic [1:0]  round_q, round_d;

  logic        in_acc;
  logic        slot_free;
  logic [63:0] fnv_h;
  logic [7:0]  fnv_b;
  logic [63:0] fnv_res;
  logic [5:0]  xs_sh;
  logic [63:0] xs_res;
  logic [63:0] mul_k;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign mask_o      = mask_q;

  // Shared FNV step: input byte in idle, build-id bytes while folding
  assign fnv_h   = (state_q == ST_IDLE) ? hash_q : v_q;
  assign fnv_b   = (state_q == ST_IDLE) ? data_byte_i : build_id_q[{cnt_q, 3'b000} +: 8];
  assign fnv_res = fnv_step(fnv_h, fnv_b);

  // Shared xor-shift unit
  always_comb begin
    case (round_q)
      2'd0:    xs_sh = XS_SHIFT0;
      2'd1:    xs_sh = XS_SHIFT1;
      default: xs_sh = XS_SHIFT2;
    endcase
  end
  assign xs_res = v_q ^ (v_q >> xs_sh);

  // Multiplier operand select per phase
  assign mul_k  = (round_q == 2'd0) ? SM_MUL_A : SM_MUL_B;
  assign mul_en = (state_q == ST_MUL) && (ph_q != PH_SUM);
  always_comb begin
    case (ph_q)
      PH_LOLO: begin mul_a = v_q[31:0];  mul_b = mul_k[31:0];  end
      PH_LOHI: begin mul_a = v_q[31:0];  mul_b = mul_k[63:32]; end
      default: begin mul_a = v_q[63:32]; mul_b = mul_k[31:0];  end
    endcase
  end

  fbh_mul32 u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && last_byte_i) state_d = ST_FOLD;
      ST_FOLD: if (cnt_q == 3'd7) state_d = ST_XS;
      ST_XS:   state_d = (round_q == ROUND_LAST) ? ST_OUT : ST_MUL;
      ST_MUL:  if (ph_q == PH_SUM) state_d = ST_XS;
      ST_OUT:  if (slot_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    hash_d      = hash_q;
    v_d         = v_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    ph_d        = ph_q;
    round_d     = round_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    build_id_d  = cfg_valid_i ? cfg_data_i : build_id_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (last_byte_i) begin
            v_d     = fnv_res;
            hash_d  = FNV_BASIS;
            cnt_d   = 3'd0;
            round_d = 2'd0;
          end else begin
            hash_d = fnv_res;
          end
        end
      end
      ST_FOLD: begin
        v_d   = fnv_res;
        cnt_d = cnt_q + 3'd1;
      end
      ST_XS: begin
        v_d  = xs_res;
        ph_d = PH_LOLO;
      end
      ST_MUL: begin
        ph_d = ph_q + 2'd1;
        case (ph_q)
          PH_LOLO: ;
          PH_LOHI: acc_d = prod;
          PH_HILO: acc_d[63:32] = acc_q[63:32] + prod[31:0];
          default: begin
            v_d     = acc_q + {prod[31:0], 32'd0};
            round_d = round_q + 2'd1;
          end
        endcase
      end
      ST_OUT: begin
        if (slot_free) begin
          mask_d      = v_q;
          out_valid_d = 1'b1;
          round_d     = 2'd0;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hash_q      <= FNV_BASIS;
      build_id_q  <= 64'd0;
      out_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
      ph_q        <= PH_LOLO;
      round_q     <= 2'd0;
    end else begin
      state_q     <= state_d;
      hash_q      <= hash_d;
      build_id_q  <= build_id_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
      ph_q        <= ph_d;
      round_q     <= round_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    acc_q  <= acc_d;
    mask_q <= mask_d;
  end

  // Checks
  `FBH_ASSERT_NEXT(a_last_restarts, in_acc && last_byte_i,
    state_q == ST_FOLD && cnt_q == 3'd0 && hash_q == FNV_BASIS,
    "last byte did not start fold with hash back at basis")
  `FBH_ASSERT_NEXT(a_result_src, !out_valid_q && state_q != ST_OUT,
    !out_valid_q, "result appeared outside output load")
  `FBH_ASSERT_NOW(a_mul_round, state_q == ST_MUL,
    round_q == 2'd0 || round_q == 2'd1, "multiply phase in closing round")

endmodule

/* bench/binding_mask_pkg.sv */
package binding_mask_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  import fbh_pkg::*;

  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;

  // Tracks the running hash and build id, queues the masks the core owes us
  class binding_mask_book;
    logic [63:0] running_hash;
    logic [63:0] build_id;
    logic [63:0] pending_masks[$];
    int          fail_count;

    function new();
      running_hash = FNV_BASIS;
      build_id     = '0;
      fail_count   = 0;
    endfunction

    static function logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    static function logic [63:0] splitmix_finish(logic [63:0] v);
      logic [63:0] t;
      t = (v ^ (v >> XS_SHIFT0)) * SM_MUL_A;
      t = (t ^ (t >> XS_SHIFT1)) * SM_MUL_B;
      return t ^ (t >> XS_SHIFT2);
    endfunction

    function void set_build_id(logic [63:0] v);
      build_id = v;
    endfunction

    // Accepted input item: update hash, on the last byte fold build id and finish
    function void take_byte(logic [7:0] data, logic last);
      logic [63:0] h;
      h = fnv_mix(running_hash, data);
      if (!last) begin
        running_hash = h;
        return;
      end
      for (int k = 0; k < 8; k++) h = fnv_mix(h, build_id[k*8 +: 8]);
      pending_masks.push_back(splitmix_finish(h));
      running_hash = FNV_BASIS;
    endfunction

    // Accepted result item: compare with the oldest expected mask
    function void check_mask(logic [63:0] actual);
      logic [63:0] want;
      if (pending_masks.size() == 0) begin
        $display("%0t mask with none expected: expected none, actual %h", $time, actual);
        fail_count++;
        return;
      end
      want = pending_masks.pop_front();
      if (actual !== want) begin
        $display("%0t mask mismatch: expected %h, actual %h", $time, want, actual);
        fail_count++;
      end
    endfunction

    function int pending();
      return pending_masks.size();
    endfunction
  endclass

endpackage

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import binding_mask_pkg::*;

  localparam int CLK_HALF      = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int MAX_GAP       = 18;
  localparam int SETTLE_CYCLES = 32;      // covers a last byte's trip through the core
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 150;
  localparam int NUM_PHASES    = 8;
  localparam int TIMEOUT_NS    = 12_000_000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] mask_o;

  binding_mask_book book;
  bit quiet_idle = 1'b0;   // both sides run without gaps
  bit hold_req   = 1'b0;   // receiver stalls its next result with the long hold-off

  always #CLK_HALF clk_i = ~clk_i;

  fnv1a_splitmix_binding_hash_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .mask_o      (mask_o)
  );

  // Offer one byte after a random gap, return once it is taken
  task automatic send_byte(input logic [7:0] data, input logic last);
    int gap;
    gap = quiet_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    book.take_byte(data, last);
  endtask

  // Stop offering, wait for every owed mask, then let the core go quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_build_id(input logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    book.set_build_id(v);
  endtask

  // Random messages: mostly short, a few long, zero bytes sprinkled in
  task automatic run_phase(input int n_items);
    int sent;
    int len;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        b = ($urandom_range(0, 5) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        send_byte(b, k == len - 1);
      end
      sent += len;
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : receiver
    int stall_len;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        stall_len = LONG_HOLD;
        hold_req  = 1'b0;
      end else begin
        stall_len = quiet_idle ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall_len > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      book.check_mask(mask_o);
    end
  end

  initial begin : sender
    logic [63:0] id;
    book = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset build id: one-byte messages at both byte extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    drain();

    // All-ones build id: name, zero separator, certificate bytes
    write_build_id(64'hffff_ffff_ffff_ffff);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b1);

    // Build id changed mid-message: fold must use the new value
    send_byte(8'h01, 1'b0);
    send_byte(8'h7f, 1'b0);
    drain();
    write_build_id(64'h0123_4567_89ab_cdef);
    send_byte(8'h00, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h55, 1'b1);

    // Random phases, each under its own build id
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        0:       id = 64'h0;
        1:       id = 64'hffff_ffff_ffff_ffff;
        2:       id = 64'h8000_0000_0000_0000;
        3:       id = 64'h1;
        default: id = {$urandom, $urandom};
      endcase
      write_build_id(id);
      quiet_idle = (p == 2 || p == 5);
      if (p == 3 || p == 6) hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    quiet_idle = 1'b0;
    drain();
    if (book.fail_count == 0 && book.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* fnv1a_splitmix_binding_hash_core.f */
+incdir+rtl
rtl/fbh_pkg.sv
rtl/fbh_mul32.sv
rtl/fnv1a_splitmix_binding_hash_core.sv
bench/binding_mask_pkg.sv
bench/tb.sv
